// File: hw/rtl/cah_pkg.sv
// Shared types and constants for the closest-approach hit selector.
// Used by cah_mac, cah_div and closest_approach_hit_select; no dependencies.
package cah_pkg;

  // Field widths of the request and result channels.
  localparam int POS_W    = 32;
  localparam int PLAYER_W = 4;
  localparam int RAD_W    = 16;

  // Internal fixed-point widths.
  localparam int V_W     = 35;   // relative motion per axis
  localparam int S_W     = 33;   // start offset and projectile step per axis
  localparam int E_W     = 52;   // miss vector per axis, Q.16 scaled
  localparam int T_W     = 17;   // perigee time, Q1.16
  localparam int SUM_W   = 70;   // dot products and squared lengths
  localparam int A_W     = 54;   // multiplier A operand
  localparam int B_W     = 56;   // multiplier B operand, split into chunks
  localparam int CHUNK_W = 14;
  localparam int CHUNKS  = B_W / CHUNK_W;
  localparam int P_W     = A_W + CHUNK_W + 1;
  localparam int ACC_W   = 112;

  localparam int PLAYER_SLOTS = 16;
  localparam logic [RAD_W-1:0] HIT_RADIUS_RST = 16'd50;

  // Opcodes of the request channel.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  // Register index of hit_radius (byte address bit 2 and up).
  localparam logic REG_HIT_RADIUS = 1'b0;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic       mul_en;
    logic       acc_clr;
    logic [1:0] sh;
  } mac_ctl_t;

  // Status of the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/cah_mac.sv
// Shared signed multiply-accumulate unit: one 54 x 15 bit partial product per cycle while mul_en is set.
// Depends on cah_pkg.
module cah_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cah_pkg::mac_ctl_t                     ctl,
  input  logic signed [cah_pkg::A_W-1:0]        a,
  input  logic signed [cah_pkg::B_W-1:0]        b,
  output logic signed [cah_pkg::ACC_W-1:0]      acc
);
  import cah_pkg::*;

  logic [CHUNK_W-1:0]        chunk;
  logic signed [CHUNK_W:0]   bc;
  logic signed [P_W-1:0]     p_r;
  logic [1:0]                sh_r;
  logic                      pv_r;
  logic signed [ACC_W-1:0]   ext;
  logic signed [ACC_W-1:0]   addend;
  logic signed [ACC_W-1:0]   acc_r;

  // Pick the chunk of B; only the top chunk carries the sign.
  always_comb begin
    chunk = b[ctl.sh*CHUNK_W +: CHUNK_W];
    if (ctl.sh == 2'(CHUNKS-1)) begin
      bc = {chunk[CHUNK_W-1], chunk};
    end else begin
      bc = {1'b0, chunk};
    end
  end

  // Align the registered partial product to its chunk position.
  always_comb begin
    ext = ACC_W'(p_r);
    case (sh_r)
      2'd0:    addend = ext;
      2'd1:    addend = ext <<< CHUNK_W;
      2'd2:    addend = ext <<< (2*CHUNK_W);
      default: addend = ext <<< (3*CHUNK_W);
    endcase
  end

  // Multiply stage, then accumulate stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.mul_en;
    end
    if (ctl.mul_en) begin
      p_r  <= a * bc;
      sh_r <= ctl.sh;
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + addend;
    end
  end

  assign acc = acc_r;

endmodule

// File: hw/rtl/cah_div.sv
// Restoring divider for the perigee time: floor(num * 65536 / den), one bit per cycle.
// Depends on cah_pkg.
module cah_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cah_pkg::SUM_W-1:0]       num,
  input  logic [cah_pkg::SUM_W-1:0]       den,
  output logic [cah_pkg::T_W-1:0]         q,
  output cah_pkg::div_stat_t              stat
);
  import cah_pkg::*;

  logic [SUM_W-1:0] r_r;
  logic [SUM_W-1:0] den_r;
  logic [T_W-1:0]   q_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SUM_W-1:0] trial;
  logic             ge;
  logic [4:0]       bit_idx;

  // The first step tests the integer bit without shifting.
  always_comb begin
    if (cnt_r == 5'd0) begin
      trial = r_r;
    end else begin
      trial = {r_r[SUM_W-2:0], 1'b0};
    end
    ge      = (trial >= den_r);
    bit_idx = 5'(T_W-1) - cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Done pulses for one cycle after the last quotient bit.
      done_r <= !start && busy_r && (cnt_r == 5'(T_W-1));
      if (start) begin
        r_r    <= num;
        den_r  <= den;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ge) begin
          r_r          <= trial - den_r;
          q_r[bit_idx] <= 1'b1;
        end else begin
          r_r <= trial;
        end
        if (cnt_r == 5'(T_W-1)) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
    end
  end

  assign q         = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hw/rtl/closest_approach_hit_select.sv
// Sequence: a load request is stored while idle; a full target test runs three 3-term dot
// products, a divide, the miss vector, the squared miss length and the strike point, all but
// the divide on the shared MAC.
// Flow: one request at a time; in_stall holds off the next one until the block is idle again,
// which after a test with last waits for a free output register; early rejections finish sooner.
// Reset: synchronous, active low; hit_radius returns to 50; mover positions and search clear.
module closest_approach_hit_select #(
  parameter int PLAYER_SLOTS = cah_pkg::PLAYER_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic signed [cah_pkg::POS_W-1:0]    in_prev_x,
  input  logic signed [cah_pkg::POS_W-1:0]    in_prev_y,
  input  logic signed [cah_pkg::POS_W-1:0]    in_prev_z,
  input  logic signed [cah_pkg::POS_W-1:0]    in_cur_x,
  input  logic signed [cah_pkg::POS_W-1:0]    in_cur_y,
  input  logic signed [cah_pkg::POS_W-1:0]    in_cur_z,
  input  logic [cah_pkg::PLAYER_W-1:0]        in_player_index,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [cah_pkg::PLAYER_W-1:0]        out_hit_player,
  output logic signed [cah_pkg::POS_W-1:0]    out_strike_x,
  output logic signed [cah_pkg::POS_W-1:0]    out_strike_y,
  output logic signed [cah_pkg::POS_W-1:0]    out_strike_z,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import cah_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_DRAIN, ST_CAPT, ST_DECIDE, ST_DIV, ST_FIN, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_DOT, PH_DEN, PH_ST, PH_E, PH_DIST, PH_STRK
  } phase_t;

  state_t                    state_r;
  phase_t                    phase_r;
  logic [1:0]                k_r;
  logic [1:0]                c_r;

  logic [RAD_W-1:0]          radius_r;
  logic [2*RAD_W-1:0]        r2_r;

  logic signed [POS_W-1:0]   mp_r [3];
  logic signed [POS_W-1:0]   mc_r [3];
  logic signed [POS_W-1:0]   tp_r [3];
  logic signed [POS_W-1:0]   tc_r [3];
  logic [PLAYER_W-1:0]       slot_r;
  logic                      last_r;

  logic signed [V_W-1:0]     v_r  [3];
  logic signed [S_W-1:0]     s0_r [3];
  logic signed [S_W-1:0]     pd_r [3];
  logic signed [E_W-1:0]     e_r  [3];
  logic signed [SUM_W-1:0]   dot_r;
  logic signed [SUM_W-1:0]   den_r;
  logic signed [SUM_W-1:0]   st_r;
  logic [T_W-1:0]            tq_r;

  logic                      found_r;
  logic [T_W-1:0]            best_time_r;
  logic [PLAYER_W-1:0]       best_player_r;
  logic signed [POS_W-1:0]   best_pos_r [3];

  logic                      out_valid_r;
  logic                      out_hit_r;
  logic [PLAYER_W-1:0]       out_player_r;
  logic signed [POS_W-1:0]   out_pos_r [3];

  mac_ctl_t                  mac_ctl;
  logic signed [A_W-1:0]     mac_a;
  logic signed [B_W-1:0]     mac_b;
  logic signed [ACC_W-1:0]   acc;

  logic                      div_start;
  logic [T_W-1:0]            div_q;
  div_stat_t                 div_stat;

  logic signed [SUM_W-1:0]   num;
  logic                      multi_term;
  logic                      dist_hit;
  logic                      better;
  logic signed [E_W-1:0]     e_val;
  logic [47:0]               strike_sum;
  logic                      cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    if (paddr[2] == REG_HIT_RADIUS) begin
      prdata = {16'd0, radius_r};
    end else begin
      prdata = '0;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (phase_r)
      PH_DOT: begin
        mac_a = A_W'(v_r[k_r]);
        mac_b = B_W'(s0_r[k_r]);
      end
      PH_DEN: begin
        mac_a = A_W'(v_r[k_r]);
        mac_b = B_W'(v_r[k_r]);
      end
      PH_ST: begin
        mac_a = A_W'(s0_r[k_r]);
        mac_b = B_W'(s0_r[k_r]);
      end
      PH_E: begin
        mac_a = A_W'(v_r[k_r]);
        mac_b = B_W'(signed'({1'b0, tq_r}));
      end
      PH_DIST: begin
        mac_a = A_W'(e_r[k_r]);
        mac_b = B_W'(e_r[k_r]);
      end
      default: begin
        mac_a = A_W'(pd_r[k_r]);
        mac_b = B_W'(signed'({1'b0, tq_r}));
      end
    endcase
  end

  assign mac_ctl.mul_en  = (state_r == ST_MUL);
  assign mac_ctl.acc_clr = (state_r == ST_CAPT) || (state_r == ST_PREP);
  assign mac_ctl.sh      = c_r;

  cah_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  assign num       = -dot_r;
  assign div_start = (state_r == ST_DECIDE) && (den_r != '0) && (dot_r <= SUM_W'(0)) &&
                     (num <= den_r);

  cah_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ($unsigned(num)),
    .den   ($unsigned(den_r)),
    .q     (div_q),
    .stat  (div_stat)
  );

  // Decisions and capture arithmetic taken from the accumulator.
  always_comb begin
    multi_term = (phase_r == PH_DOT) || (phase_r == PH_DEN) || (phase_r == PH_ST) ||
                 (phase_r == PH_DIST);
    dist_hit   = $unsigned(acc) < ACC_W'({r2_r, 48'd0});
    better     = !found_r || (tq_r < best_time_r);
    e_val      = acc[E_W-1:0] + {{3{s0_r[k_r][S_W-1]}}, s0_r[k_r], 16'd0};
    strike_sum = acc[47:0] + {mp_r[k_r], 16'h8000};
  end

  assign in_stall = (state_r != ST_IDLE);

  // Sequencer, search state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= PH_DOT;
      k_r           <= '0;
      c_r           <= '0;
      radius_r      <= HIT_RADIUS_RST;
      found_r       <= 1'b0;
      best_time_r   <= '0;
      best_player_r <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        mp_r[i]       <= '0;
        mc_r[i]       <= '0;
        best_pos_r[i] <= '0;
      end
    end else begin
      r2_r <= radius_r * radius_r;
      if (cfg_wr && paddr[2] == REG_HIT_RADIUS) begin
        radius_r <= pwdata[RAD_W-1:0];
      end
      if (out_valid_r && !out_stall && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_opcode == OP_LOAD) begin
              mp_r[0] <= in_prev_x;
              mp_r[1] <= in_prev_y;
              mp_r[2] <= in_prev_z;
              mc_r[0] <= in_cur_x;
              mc_r[1] <= in_cur_y;
              mc_r[2] <= in_cur_z;
              found_r       <= 1'b0;
              best_time_r   <= '0;
              best_player_r <= '0;
              for (int i = 0; i < 3; i++) begin
                best_pos_r[i] <= '0;
              end
            end else begin
              tp_r[0] <= in_prev_x;
              tp_r[1] <= in_prev_y;
              tp_r[2] <= in_prev_z;
              tc_r[0] <= in_cur_x;
              tc_r[1] <= in_cur_y;
              tc_r[2] <= in_cur_z;
              slot_r  <= in_player_index;
              last_r  <= in_last;
              state_r <= ST_PREP;
            end
          end
        end

        // Relative motion, start offset and projectile step.
        ST_PREP: begin
          for (int i = 0; i < 3; i++) begin
            v_r[i]  <= (V_W'(tc_r[i]) - V_W'(tp_r[i])) - (V_W'(mc_r[i]) - V_W'(mp_r[i]));
            s0_r[i] <= S_W'(tp_r[i]) - S_W'(mp_r[i]);
            pd_r[i] <= S_W'(mc_r[i]) - S_W'(mp_r[i]);
          end
          phase_r <= PH_DOT;
          k_r     <= '0;
          c_r     <= '0;
          if (32'(slot_r) < PLAYER_SLOTS) begin
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_FIN;
          end
        end

        // Issue one chunk per cycle; the dot-product and squared-length sums run over all three axes.
        ST_MUL: begin
          c_r <= c_r + 2'd1;
          if (c_r == 2'(CHUNKS-1)) begin
            if (multi_term && k_r != 2'd2) begin
              k_r <= k_r + 2'd1;
            end else begin
              state_r <= ST_DRAIN;
            end
          end
        end

        ST_DRAIN: begin
          state_r <= ST_CAPT;
        end

        ST_CAPT: begin
          case (phase_r)
            PH_DOT: begin
              dot_r   <= acc[SUM_W-1:0];
              phase_r <= PH_DEN;
              k_r     <= '0;
              state_r <= ST_MUL;
            end
            PH_DEN: begin
              den_r   <= acc[SUM_W-1:0];
              phase_r <= PH_ST;
              k_r     <= '0;
              state_r <= ST_MUL;
            end
            PH_ST: begin
              st_r    <= acc[SUM_W-1:0];
              state_r <= ST_DECIDE;
            end
            PH_E: begin
              e_r[k_r] <= e_val;
              state_r  <= ST_MUL;
              if (k_r == 2'd2) begin
                phase_r <= PH_DIST;
                k_r     <= '0;
              end else begin
                k_r <= k_r + 2'd1;
              end
            end
            PH_DIST: begin
              k_r <= '0;
              if (dist_hit && better) begin
                phase_r <= PH_STRK;
                state_r <= ST_MUL;
              end else begin
                state_r <= ST_FIN;
              end
            end
            default: begin
              best_pos_r[k_r] <= strike_sum[47:16];
              if (k_r == 2'd2) begin
                found_r       <= 1'b1;
                best_time_r   <= tq_r;
                best_player_r <= slot_r;
                state_r       <= ST_FIN;
              end else begin
                k_r     <= k_r + 2'd1;
                state_r <= ST_MUL;
              end
            end
          endcase
        end

        // Classify the perigee: no motion, in the past, beyond the interval, or divide.
        ST_DECIDE: begin
          phase_r <= PH_E;
          k_r     <= '0;
          if (den_r == '0) begin
            tq_r    <= '0;
            state_r <= ST_MUL;
          end else if (dot_r > SUM_W'(0)) begin
            if ($unsigned(st_r) >= SUM_W'({r2_r, 16'd0})) begin
              state_r <= ST_FIN;
            end else begin
              tq_r    <= '0;
              state_r <= ST_MUL;
            end
          end else if (num > den_r) begin
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_stat.done) begin
            tq_r    <= div_q;
            state_r <= ST_MUL;
          end
        end

        ST_FIN: begin
          if (last_r) begin
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_IDLE;
          end
        end

        // Hand the result over once the output register is free.
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_hit_r    <= found_r;
            out_player_r <= found_r ? best_player_r : '0;
            for (int i = 0; i < 3; i++) begin
              out_pos_r[i]  <= found_r ? best_pos_r[i] : '0;
              best_pos_r[i] <= '0;
            end
            found_r       <= 1'b0;
            best_time_r   <= '0;
            best_player_r <= '0;
            state_r       <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_hit_player = out_player_r;
  assign out_strike_x   = out_pos_r[0];
  assign out_strike_y   = out_pos_r[1];
  assign out_strike_z   = out_pos_r[2];

`ifndef NO_ASSERTIONS
  // A new result only appears after the emit step.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result appeared outside the emit step");

  // A miss carries an all-zero payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_player_r == '0 && out_pos_r[0] == '0 &&
                                     out_pos_r[1] == '0 && out_pos_r[2] == '0))
    else $error("miss result with nonzero payload");

  // The divider is never restarted while it is working.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
`endif

endmodule
